// ----- hdl/vdd_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// vdd_pkg
// Shared types and constants for the varint date-time record decoder.
// ---------------------------------------------------------------------------
package vdd_pkg;

  // Byte layout: bit 7 continues the value, bits 6..0 carry payload
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CONT_IDX  = 7;
  localparam int unsigned PAYLOAD_W = 7;

  // One decoded value holds at most four payload groups
  localparam int unsigned VAL_W     = 28;
  localparam int unsigned SHIFT_W   = 5;
  localparam logic [SHIFT_W-1:0] MAX_SHIFT  = SHIFT_W'(32 - 7);
  localparam logic [SHIFT_W-1:0] SHIFT_STEP = SHIFT_W'(PAYLOAD_W);

  // Field counter saturates at its all-ones value
  localparam int unsigned COUNT_W = 8;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
  localparam logic [COUNT_W-1:0] MIN_FIELDS = COUNT_W'(3);

  // Date-time fields on the result channel
  localparam int unsigned NUM_OUT   = 7;
  localparam int unsigned YEAR_W    = 16;
  localparam int unsigned SMALL_W   = 8;
  localparam int unsigned STATUS_W  = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_TOO_LONG  = 3'd1,
    ST_FEW       = 3'd2,
    ST_RANGE     = 3'd3,
    ST_EXTRA     = 3'd4
  } status_t;

  // Record state as it stands after the current byte
  typedef struct packed {
    logic [NUM_OUT-1:0][VAL_W-1:0] slot;
    logic [COUNT_W-1:0]            count;
    logic                          too_long;
    logic                          extra;
  } rec_view_t;

endpackage
`default_nettype wire

// ----- hdl/vdd_field_acc.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// vdd_field_acc
// Per-record varint accumulator: field store, shift position, continuation
// flag, saturating field count and too-long flag.
// ---------------------------------------------------------------------------
module vdd_field_acc #(
  parameter int unsigned FIELD_SLOTS = 7
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     step,
  input  wire logic [vdd_pkg::BYTE_W-1:0] data_byte,
  input  wire logic                     end_of_record,
  output vdd_pkg::rec_view_t            view
);
  import vdd_pkg::*;

  logic [FIELD_SLOTS-1:0][VAL_W-1:0] store_r, store_nxt;
  logic [SHIFT_W-1:0]                shift_r, shift_nxt;
  logic                              cont_r, cont_nxt;
  logic [COUNT_W-1:0]                seen_r, seen_nxt;
  logic                              long_r, long_nxt;
  logic [VAL_W-1:0]                  payload;

  assign payload = VAL_W'(data_byte[PAYLOAD_W-1:0]);

  // Fold one byte into the record state
  always_comb begin
    store_nxt = store_r;
    shift_nxt = shift_r;
    cont_nxt  = cont_r;
    seen_nxt  = seen_r;
    long_nxt  = long_r;
    if (!long_r) begin
      if (!cont_r) begin
        shift_nxt = '0;
        if (seen_r != COUNT_MAX) begin
          seen_nxt = seen_r + COUNT_W'(1);
        end
      end
      cont_nxt = data_byte[CONT_IDX];
      if (shift_nxt > MAX_SHIFT) begin
        long_nxt = 1'b1;
      end else begin
        for (int j = 0; j < FIELD_SLOTS; j++) begin
          if (seen_nxt == COUNT_W'(j + 1)) begin
            store_nxt[j] = store_r[j] | (payload << shift_nxt);
          end
        end
        shift_nxt = shift_nxt + SHIFT_STEP;
      end
    end
  end

  // Advance on each item, clear after the record's last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= '0;
      shift_r <= '0;
      cont_r  <= 1'b0;
      seen_r  <= '0;
      long_r  <= 1'b0;
    end else if (step) begin
      if (end_of_record) begin
        store_r <= '0;
        shift_r <= '0;
        cont_r  <= 1'b0;
        seen_r  <= '0;
        long_r  <= 1'b0;
      end else begin
        store_r <= store_nxt;
        shift_r <= shift_nxt;
        cont_r  <= cont_nxt;
        seen_r  <= seen_nxt;
        long_r  <= long_nxt;
      end
    end
  end

  // Present the updated record; output slots past the store read zero
  for (genvar i = 0; i < NUM_OUT; i++) begin : g_view
    if (i < FIELD_SLOTS) begin : g_slot
      assign view.slot[i] = store_nxt[i];
    end else begin : g_zero
      assign view.slot[i] = '0;
    end
  end
  assign view.count    = seen_nxt;
  assign view.too_long = long_nxt;
  assign view.extra    = (seen_nxt > COUNT_W'(FIELD_SLOTS));

endmodule
`default_nettype wire

// ----- hdl/vdd_result_stage.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// vdd_result_stage
// Status priority, field masking and the result register.
// ---------------------------------------------------------------------------
module vdd_result_stage (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        load,
  input  wire vdd_pkg::rec_view_t          view,
  input  wire logic                        out_ready,
  output logic                             out_valid,
  output logic [vdd_pkg::YEAR_W-1:0]       out_year,
  output logic [vdd_pkg::SMALL_W-1:0]      out_month,
  output logic [vdd_pkg::SMALL_W-1:0]      out_day,
  output logic [vdd_pkg::SMALL_W-1:0]      out_hour,
  output logic [vdd_pkg::SMALL_W-1:0]      out_minute,
  output logic [vdd_pkg::SMALL_W-1:0]      out_second,
  output logic [vdd_pkg::VAL_W-1:0]        out_microsecond,
  output logic [vdd_pkg::COUNT_W-1:0]      out_field_count,
  output logic [vdd_pkg::STATUS_W-1:0]     out_status
);
  import vdd_pkg::*;

  logic                valid_r, valid_nxt;
  logic [YEAR_W-1:0]   year_r;
  logic [SMALL_W-1:0]  month_r, day_r, hour_r, minute_r, second_r;
  logic [VAL_W-1:0]    usec_r;
  logic [COUNT_W-1:0]  count_r;
  status_t             status_r, status_nxt;
  logic                out_of_range;
  logic                zero_fields;

  // Flag a year above 16 bits or another date field above 8 bits
  always_comb begin
    out_of_range = |view.slot[0][VAL_W-1:YEAR_W];
    for (int i = 1; i < 6; i++) begin
      out_of_range = out_of_range | (|view.slot[i][VAL_W-1:SMALL_W]);
    end
  end

  // Pick the status in priority order
  always_comb begin
    if (view.too_long) begin
      status_nxt = ST_TOO_LONG;
    end else if (view.count < MIN_FIELDS) begin
      status_nxt = ST_FEW;
    end else if (out_of_range) begin
      status_nxt = ST_RANGE;
    end else if (view.extra) begin
      status_nxt = ST_EXTRA;
    end else begin
      status_nxt = ST_OK;
    end
  end

  assign zero_fields = (status_nxt == ST_TOO_LONG) || (status_nxt == ST_FEW) ||
                       (status_nxt == ST_RANGE);

  // Hold the result until taken; a new one may load as the old one leaves
  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      year_r   <= zero_fields ? '0 : view.slot[0][YEAR_W-1:0];
      month_r  <= zero_fields ? '0 : view.slot[1][SMALL_W-1:0];
      day_r    <= zero_fields ? '0 : view.slot[2][SMALL_W-1:0];
      hour_r   <= zero_fields ? '0 : view.slot[3][SMALL_W-1:0];
      minute_r <= zero_fields ? '0 : view.slot[4][SMALL_W-1:0];
      second_r <= zero_fields ? '0 : view.slot[5][SMALL_W-1:0];
      usec_r   <= zero_fields ? '0 : view.slot[6];
      count_r  <= view.count;
      status_r <= status_nxt;
    end
  end

  assign out_valid       = valid_r;
  assign out_year        = year_r;
  assign out_month       = month_r;
  assign out_day         = day_r;
  assign out_hour        = hour_r;
  assign out_minute      = minute_r;
  assign out_second      = second_r;
  assign out_microsecond = usec_r;
  assign out_field_count = count_r;
  assign out_status      = status_r;

endmodule
`default_nettype wire

// ----- hdl/varint_datetime_decoder_unit.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// varint_datetime_decoder_unit
// Byte-serial LEB128 varint decoder for packed date-time records.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one encoded byte per item plus
//   an end-of-record mark. Bytes build unsigned little-endian base-128
//   values that fill year, month, day, hour, minute, second, microsecond.
//   Result channel (out_valid/out_ready) carries one item per record, with
//   the seven fields, the saturating field count and the status code.
//   Path: the record's last byte passes the input register, then the result
//   register, where out_valid rises; the byte waits in the input register
//   while a held result has not been taken.
//   Throughput: one byte per cycle unless a last byte waits on a held result;
//   the per-byte work is a mask, a shift and an OR into one field-store slot.
//   Reset: rst_n clears the record state, the input stage and the result
//   valid; the block is ready as soon as reset is released.
//   Stall: bytes that do not end a record keep flowing while a result waits;
//   a last byte waits in the input register only while a result is still
//   held and out_ready is low.
// ---------------------------------------------------------------------------
module varint_datetime_decoder_unit #(
  parameter int unsigned FIELD_SLOTS = 7
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [vdd_pkg::BYTE_W-1:0]  in_data_byte,
  input  wire logic                        in_end_of_record,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [vdd_pkg::YEAR_W-1:0]       out_year,
  output logic [vdd_pkg::SMALL_W-1:0]      out_month,
  output logic [vdd_pkg::SMALL_W-1:0]      out_day,
  output logic [vdd_pkg::SMALL_W-1:0]      out_hour,
  output logic [vdd_pkg::SMALL_W-1:0]      out_minute,
  output logic [vdd_pkg::SMALL_W-1:0]      out_second,
  output logic [vdd_pkg::VAL_W-1:0]        out_microsecond,
  output logic [vdd_pkg::COUNT_W-1:0]      out_field_count,
  output logic [vdd_pkg::STATUS_W-1:0]     out_status
);
  import vdd_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_eor_r;
  logic              s1_go;
  logic              out_free;
  logic              in_take;
  rec_view_t         view;

  // Input stage moves on unless a last byte meets a held result
  assign out_free = !out_valid || out_ready;
  assign s1_go    = s1_valid_r && (!s1_eor_r || out_free);
  assign in_ready = !s1_valid_r || s1_go;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_data_byte;
      s1_eor_r  <= in_end_of_record;
    end
  end

  vdd_field_acc #(
    .FIELD_SLOTS(FIELD_SLOTS)
  ) u_acc (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (s1_go),
    .data_byte     (s1_byte_r),
    .end_of_record (s1_eor_r),
    .view          (view)
  );

  vdd_result_stage u_res (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (s1_go && s1_eor_r),
    .view            (view),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_year        (out_year),
    .out_month       (out_month),
    .out_day         (out_day),
    .out_hour        (out_hour),
    .out_minute      (out_minute),
    .out_second      (out_second),
    .out_microsecond (out_microsecond),
    .out_field_count (out_field_count),
    .out_status      (out_status)
  );

  // A new result appears only after a last byte was processed
  a_result_from_eor: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_go && s1_eor_r) |=> !$rose(out_valid))
    else $error("result raised without an end-of-record byte");

  // Input stalls only behind a last byte blocked by a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && s1_eor_r && out_valid && !out_ready))
    else $error("input stalled without a blocked result");

  // Error results carry zero value fields
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_TOO_LONG || out_status == ST_FEW ||
                   out_status == ST_RANGE))
    |-> (out_year == '0 && out_month == '0 && out_day == '0 &&
         out_microsecond == '0))
    else $error("error result with nonzero fields");

  // Under three fields always reports too long or too few
  a_few_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_field_count < MIN_FIELDS)
    |-> (out_status == ST_TOO_LONG || out_status == ST_FEW))
    else $error("short record reported with wrong status");

endmodule
`default_nettype wire
